/* rtl/epr_pkg.sv */
// Package for the Euler point rotator: CORDIC constants, arctangent table,
// internal widths and pipeline latencies. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package epr_pkg;

  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

  // Sine/cosine datapath width (Q1.30 plus headroom) and phase residue width.
  localparam int SW = 33;
  localparam int ZW = 32;

  localparam logic [31:0]       PHASE_MUL   = 32'd3482026236;
  localparam logic signed [SW-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // Phase multiply, phase setup, CORDIC stages, quadrant map.
  localparam int CORDIC_LATENCY = CORDIC_STAGES + 3;
  // Product stage, round-and-sum stage.
  localparam int ROT_LATENCY    = 2;

endpackage
`default_nettype wire

/* rtl/euler_point_rotator.sv */
// Euler point rotator: p' = M(a) * X(b) * Z(c) * p, Q8.8 points, Q4.12 angles.
// An input transaction passes the sine/cosine pipeline, three rotations and
// the saturation register; throughput one transaction per cycle unless stalled.
// The whole pipeline advances together; it holds while a result waits.
// Reset clears only the valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_point_rotator #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   point_valid_i,
  output logic                        point_ready_o,
  input  wire logic [COORD_WIDTH-1:0] point_x_i,
  input  wire logic [COORD_WIDTH-1:0] point_y_i,
  input  wire logic [COORD_WIDTH-1:0] point_z_i,
  input  wire logic [ANGLE_WIDTH-1:0] angle_a_i,
  input  wire logic [ANGLE_WIDTH-1:0] angle_b_i,
  input  wire logic [ANGLE_WIDTH-1:0] angle_c_i,
  output logic                        rot_valid_o,
  input  wire logic                   rot_ready_i,
  output logic [COORD_WIDTH-1:0]      rot_x_o,
  output logic [COORD_WIDTH-1:0]      rot_y_o,
  output logic [COORD_WIDTH-1:0]      rot_z_o
);
  import epr_pkg::*;

  // Internal coordinate width: rotations keep the norm, so two guard bits do.
  localparam int IW    = COORD_WIDTH + 2;
  localparam int DEPTH = CORDIC_LATENCY + 3 * ROT_LATENCY + 1;

  logic             en;
  logic [DEPTH-1:0] valid_q, valid_d;

  // Advance everything when the output slot is free or being drained.
  assign en            = !valid_q[DEPTH-1] || rot_ready_i;
  assign point_ready_o = en;

  assign valid_d = {valid_q[DEPTH-2:0], point_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // Sine and cosine of each angle.
  logic signed [SW-1:0] sa, ca, sb, cb, sc, cc;

  epr_cordic #(.AW(ANGLE_WIDTH)) u_cordic_a (
    .clk_i, .en_i(en), .angle_i(angle_a_i), .sin_o(sa), .cos_o(ca)
  );
  epr_cordic #(.AW(ANGLE_WIDTH)) u_cordic_b (
    .clk_i, .en_i(en), .angle_i(angle_b_i), .sin_o(sb), .cos_o(cb)
  );
  epr_cordic #(.AW(ANGLE_WIDTH)) u_cordic_c (
    .clk_i, .en_i(en), .angle_i(angle_c_i), .sin_o(sc), .cos_o(cc)
  );

  // Hold the point alongside the sine/cosine pipeline.
  logic signed [IW-1:0] px, py, pz;
  logic [3*IW-1:0]      pt_d, pt_q;

  assign pt_d = {IW'(signed'(point_x_i)), IW'(signed'(point_y_i)),
                 IW'(signed'(point_z_i))};

  epr_delay #(.W(3*IW), .D(CORDIC_LATENCY)) u_pt_dly (
    .clk_i, .en_i(en), .d_i(pt_d), .q_o(pt_q)
  );

  assign px = pt_q[3*IW-1:2*IW];
  assign py = pt_q[2*IW-1:IW];
  assign pz = pt_q[IW-1:0];

  // Rotate about z with angle c.
  logic signed [IW-1:0] x1, y1, z1;

  epr_rot #(.IW(IW)) u_rot_z (
    .clk_i, .en_i(en), .u_i(px), .v_i(py), .cos_i(cc), .sin_i(sc),
    .t0_o(x1), .t1_o(y1)
  );
  epr_delay #(.W(IW), .D(ROT_LATENCY)) u_z1_dly (
    .clk_i, .en_i(en), .d_i(pz), .q_o(z1)
  );

  // Rotate about x with angle b; its sine/cosine wait one rotation.
  logic signed [IW-1:0] x2, y2, z2;
  logic [2*SW-1:0]      scb_q;

  epr_delay #(.W(2*SW), .D(ROT_LATENCY)) u_scb_dly (
    .clk_i, .en_i(en), .d_i({sb, cb}), .q_o(scb_q)
  );
  epr_rot #(.IW(IW)) u_rot_x (
    .clk_i, .en_i(en), .u_i(y1), .v_i(z1),
    .cos_i(scb_q[SW-1:0]), .sin_i(scb_q[2*SW-1:SW]),
    .t0_o(y2), .t1_o(z2)
  );
  epr_delay #(.W(IW), .D(ROT_LATENCY)) u_x2_dly (
    .clk_i, .en_i(en), .d_i(x1), .q_o(x2)
  );

  // Y-axis form with angle a: feeding (z, x) gives t0 = z', t1 = x'.
  logic signed [IW-1:0] x3, y3, z3;
  logic [2*SW-1:0]      sca_q;

  epr_delay #(.W(2*SW), .D(2*ROT_LATENCY)) u_sca_dly (
    .clk_i, .en_i(en), .d_i({sa, ca}), .q_o(sca_q)
  );
  epr_rot #(.IW(IW)) u_rot_y (
    .clk_i, .en_i(en), .u_i(z2), .v_i(x2),
    .cos_i(sca_q[SW-1:0]), .sin_i(sca_q[2*SW-1:SW]),
    .t0_o(z3), .t1_o(x3)
  );
  epr_delay #(.W(IW), .D(ROT_LATENCY)) u_y3_dly (
    .clk_i, .en_i(en), .d_i(y2), .q_o(y3)
  );

  // Clamp to the coordinate range and register the result.
  function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [IW-1:0] v);
    logic ovf;
    ovf = (v[IW-1:COORD_WIDTH-1] != {(IW-COORD_WIDTH+1){1'b0}}) &&
          (v[IW-1:COORD_WIDTH-1] != {(IW-COORD_WIDTH+1){1'b1}});
    if (!ovf) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[IW-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_x_o <= sat(x3);
      rot_y_o <= sat(y3);
      rot_z_o <= sat(z3);
    end
  end

  assign rot_valid_o = valid_q[DEPTH-1];

endmodule
`default_nettype wire

/* rtl/epr_delay.sv */
// Enable-gated delay line used to keep side data aligned with the pipeline.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module epr_delay #(
  parameter int W = 16,
  parameter int D = 2
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[D-1];

endmodule
`default_nettype wire

/* rtl/epr_cordic.sv */
// Pipelined sine/cosine: phase multiply, 24 CORDIC steps in 8 stages, quadrant map.
// Depends on epr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module epr_cordic #(
  parameter int AW = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [AW-1:0]         angle_i,
  output logic signed [epr_pkg::SW-1:0] sin_o,
  output logic signed [epr_pkg::SW-1:0] cos_o
);
  import epr_pkg::*;

  localparam int PW = AW + 33;

  logic signed [PW-1:0] prod;
  logic [79:0]          prod_ext;
  logic [47:0]          prod_q;
  logic [47:0]          phase_sum;

  logic signed [SW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [SW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES+1];
  logic [1:0]           quad_q [CORDIC_STAGES+1];

  assign prod     = $signed(angle_i) * $signed({1'b0, PHASE_MUL});
  assign prod_ext = {{(80-PW){prod[PW-1]}}, prod};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_ext[47:0];
    end
  end

  // Round the turn fraction, split off the quadrant, seed the rotation.
  assign phase_sum = prod_q + 48'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= phase_sum[47:46];
      z_q[0]    <= {2'b00, phase_sum[45:16]};
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    logic signed [SW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] zs;

    always_comb begin
      xs = x_q[g];
      ys = y_q[g];
      zs = z_q[g];
      dx = '0;
      dy = '0;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        dx = ys >>> (g * STEPS_PER_STAGE + j);
        dy = xs >>> (g * STEPS_PER_STAGE + j);
        if (!zs[ZW-1]) begin
          xs = xs - dx;
          ys = ys + dy;
          zs = zs - ATAN_TAB[g * STEPS_PER_STAGE + j];
        end else begin
          xs = xs + dx;
          ys = ys - dy;
          zs = zs + ATAN_TAB[g * STEPS_PER_STAGE + j];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]    <= xs;
        y_q[g+1]    <= ys;
        z_q[g+1]    <= zs;
        quad_q[g+1] <= quad_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[CORDIC_STAGES])
        2'd0: begin
          cos_o <= x_q[CORDIC_STAGES];
          sin_o <= y_q[CORDIC_STAGES];
        end
        2'd1: begin
          cos_o <= -y_q[CORDIC_STAGES];
          sin_o <= x_q[CORDIC_STAGES];
        end
        2'd2: begin
          cos_o <= -x_q[CORDIC_STAGES];
          sin_o <= -y_q[CORDIC_STAGES];
        end
        default: begin
          cos_o <= y_q[CORDIC_STAGES];
          sin_o <= -x_q[CORDIC_STAGES];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/epr_rot.sv */
// One plane rotation: t0 = u*c - v*s, t1 = u*s + v*c, rounded from Q1.30.
// Two stages: products, then sum and round. Depends on epr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module epr_rot #(
  parameter int IW = 18
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [IW-1:0]     u_i,
  input  wire logic signed [IW-1:0]     v_i,
  input  wire logic signed [epr_pkg::SW-1:0] cos_i,
  input  wire logic signed [epr_pkg::SW-1:0] sin_i,
  output logic signed [IW-1:0]          t0_o,
  output logic signed [IW-1:0]          t1_o
);
  import epr_pkg::*;

  localparam int MW = IW + SW;

  logic signed [MW-1:0] uc_q, vs_q, us_q, vc_q;
  logic signed [MW:0]   sum0, sum1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uc_q <= u_i * cos_i;
      vs_q <= v_i * sin_i;
      us_q <= u_i * sin_i;
      vc_q <= v_i * cos_i;
    end
  end

  assign sum0 = (MW+1)'(uc_q) - (MW+1)'(vs_q) + (MW+1)'(2**29);
  assign sum1 = (MW+1)'(us_q) + (MW+1)'(vc_q) + (MW+1)'(2**29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_o <= sum0[30+IW-1:30];
      t1_o <= sum1[30+IW-1:30];
    end
  end

endmodule
`default_nettype wire

/* rtl/epr_checker.sv */
// Port-level checker for euler_point_rotator, bound to the top level.
// Depends on euler_point_rotator's ports only.
`timescale 1ns / 1ps
`default_nettype none
module epr_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   point_ready_o,
  input wire logic                   rot_valid_o,
  input wire logic                   rot_ready_i,
  input wire logic [COORD_WIDTH-1:0] rot_x_o,
  input wire logic [COORD_WIDTH-1:0] rot_y_o,
  input wire logic [COORD_WIDTH-1:0] rot_z_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_valid_o && !rot_ready_i |=> rot_valid_o)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_valid_o && !rot_ready_i |=>
      $stable(rot_x_o) && $stable(rot_y_o) && $stable(rot_z_o))
    else $error("result payload changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_ready_o == (!rot_valid_o || rot_ready_i))
    else $error("input ready does not follow output slot");

  // Valid bits are cleared asynchronously when reset asserts, so none is seen while reset holds.
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !rot_valid_o)
    else $error("result valid during reset");

endmodule

bind euler_point_rotator epr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_epr_checker (
  .clk_i, .rst_ni, .point_ready_o, .rot_valid_o, .rot_ready_i,
  .rot_x_o, .rot_y_o, .rot_z_o
);
`default_nettype wire
